@@ rtl/core/lsqe_pkg.sv @@
package lsqe_pkg;

  // Field widths
  localparam int CoordW  = 24;
  localparam int WidthW  = 16;
  localparam int ColorW  = 32;

  // Internal widths
  localparam int DiffW   = CoordW + 1;
  localparam int SqW     = 2 * DiffW;
  localparam int RadW    = 64;
  localparam int RootW   = 32;
  localparam int DivW    = 48;
  localparam int QuotW   = 17;
  localparam int UnitW   = 15;
  localparam int ExtW    = 17;
  localparam int ProdW   = 32;
  localparam int OffW    = 19;
  localparam int SumW    = 27;

  localparam int NumCorners  = 4;
  localparam int NumVertices = 6;
  localparam int VtxCntW     = 3;
  localparam int FracBitsDef = 8;
  localparam int UnitMax     = 32767;
  localparam int RoundHalf   = 16384;
  localparam int CoordMax    = (1 << (CoordW - 1)) - 1;

  typedef struct packed {
    logic signed [CoordW-1:0] sx;
    logic signed [CoordW-1:0] sy;
    logic signed [CoordW-1:0] ex;
    logic signed [CoordW-1:0] ey;
    logic [WidthW-1:0]        w;
    logic [ColorW-1:0]        rgba;
  } seg_t;

  typedef struct packed {
    seg_t                    seg;
    logic signed [DiffW-1:0] dx;
    logic signed [DiffW-1:0] dy;
    logic [SqW-1:0]          sq;
    logic                    zero;
  } job_t;

  typedef struct packed {
    seg_t                                seg;
    logic [NumCorners-1:0][CoordW-1:0]   cx;
    logic [NumCorners-1:0][CoordW-1:0]   cy;
  } quad_t;

  // Clamp a wide corner sum into the coordinate range
  function automatic logic [CoordW-1:0] sat_coord(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] hi;
    logic signed [SumW-1:0] lo;
    hi = $signed(SumW'(CoordMax));
    lo = -hi - $signed(SumW'(1));
    if (v > hi) begin
      sat_coord = hi[CoordW-1:0];
    end else if (v < lo) begin
      sat_coord = lo[CoordW-1:0];
    end else begin
      sat_coord = v[CoordW-1:0];
    end
  endfunction

  // Widen a coordinate with its sign
  function automatic logic signed [SumW-1:0] ext_coord(input logic [CoordW-1:0] v);
    ext_coord = $signed({{(SumW-CoordW){v[CoordW-1]}}, v});
  endfunction

endpackage

@@ rtl/core/lsqe_front.sv @@
module lsqe_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lsqe_pkg::seg_t     seg_i,
  output logic               job_valid_o,
  input  logic               job_ready_i,
  output lsqe_pkg::job_t     job_o
);

  logic                             a_valid_q;
  lsqe_pkg::seg_t                   a_seg_q;
  logic signed [lsqe_pkg::DiffW-1:0] a_dx_q, a_dy_q;
  logic                             b_valid_q;
  lsqe_pkg::seg_t                   b_seg_q;
  logic signed [lsqe_pkg::DiffW-1:0] b_dx_q, b_dy_q;
  logic signed [lsqe_pkg::SqW-1:0]   sqx, sqy, b_sqx_q, b_sqy_q;
  logic                             a_adv, b_adv;

  assign b_adv      = !b_valid_q || job_ready_i;
  assign a_adv      = !a_valid_q || b_adv;
  assign in_stall_o = !a_adv;

  assign sqx = a_dx_q * a_dx_q;
  assign sqy = a_dy_q * a_dy_q;

  // Advance the valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_adv) a_valid_q <= in_valid_i;
      if (b_adv) b_valid_q <= a_valid_q;
    end
  end

  // Take the endpoint differences, then square them
  always_ff @(posedge clk_i) begin
    if (a_adv && in_valid_i) begin
      a_seg_q <= seg_i;
      a_dx_q  <= $signed({seg_i.ex[lsqe_pkg::CoordW-1], seg_i.ex})
               - $signed({seg_i.sx[lsqe_pkg::CoordW-1], seg_i.sx});
      a_dy_q  <= $signed({seg_i.ey[lsqe_pkg::CoordW-1], seg_i.ey})
               - $signed({seg_i.sy[lsqe_pkg::CoordW-1], seg_i.sy});
    end
    if (b_adv && a_valid_q) begin
      b_seg_q <= a_seg_q;
      b_dx_q  <= a_dx_q;
      b_dy_q  <= a_dy_q;
      b_sqx_q <= sqx;
      b_sqy_q <= sqy;
    end
  end

  // Classify the segment and hand it to the queue
  assign job_valid_o = b_valid_q;
  always_comb begin
    job_o.seg  = b_seg_q;
    job_o.dx   = b_dx_q;
    job_o.dy   = b_dy_q;
    job_o.sq   = lsqe_pkg::SqW'($unsigned(b_sqx_q) + $unsigned(b_sqy_q));
    job_o.zero = (b_dx_q == '0) && (b_dy_q == '0);
  end

endmodule

@@ rtl/core/lsqe_queue.sv @@
module lsqe_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  lsqe_pkg::job_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output lsqe_pkg::job_t pop_data_o
);

  lsqe_pkg::job_t mem_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     count_q;
  logic           push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // Track pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      unique case ({push, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  // Store the entry
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

@@ rtl/core/lsqe_norm.sv @@
module lsqe_norm #(
  parameter int FracBits = lsqe_pkg::FracBitsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_valid_i,
  output logic            job_ready_o,
  input  lsqe_pkg::job_t  job_i,
  output logic            quad_valid_o,
  input  logic            quad_ready_i,
  output lsqe_pkg::quad_t quad_o
);

  localparam int StW = 3;
  localparam logic [StW-1:0] StIdle = 3'd0;
  localparam logic [StW-1:0] StRoot = 3'd1;
  localparam logic [StW-1:0] StDiv  = 3'd2;
  localparam logic [StW-1:0] StMul  = 3'd3;
  localparam logic [StW-1:0] StRnd  = 3'd4;
  localparam logic [StW-1:0] StDone = 3'd5;
  localparam int DivSteps = lsqe_pkg::QuotW;
  localparam int CntW     = $clog2(DivSteps);

  logic [StW-1:0]                 state_q, state_d;
  lsqe_pkg::job_t                 job_q, job_d;
  logic [lsqe_pkg::RadW-1:0]      rad_q, rad_d, res_q, res_d, bit_q, bit_d, trial, res_step;
  logic                           take;
  logic [lsqe_pkg::RootW-1:0]     root;
  logic [lsqe_pkg::DiffW-1:0]     magx, magy;
  logic [lsqe_pkg::DivW-1:0]      remx_q, remx_d, remy_q, remy_d, dv_q, dv_d;
  logic [lsqe_pkg::QuotW-1:0]     qx_q, qx_d, qy_q, qy_d;
  logic [CntW-1:0]                cnt_q, cnt_d;
  logic [lsqe_pkg::UnitW-1:0]     ucx, ucy;
  logic [lsqe_pkg::ExtW-1:0]      ext;
  logic [lsqe_pkg::ProdW-1:0]     prx_q, prx_d, pry_q, pry_d, rsx, rsy;
  logic signed [lsqe_pkg::OffW-1:0] ox_q, ox_d, oy_q, oy_d;

  // One root bit per cycle
  assign trial    = res_q + bit_q;
  assign take     = (rad_q >= trial);
  assign res_step = take ? ((res_q >> 1) + bit_q) : (res_q >> 1);
  assign root     = res_step[lsqe_pkg::RootW-1:0];

  assign magx = job_q.dx[lsqe_pkg::DiffW-1] ? lsqe_pkg::DiffW'(-job_q.dx)
                                             : lsqe_pkg::DiffW'(job_q.dx);
  assign magy = job_q.dy[lsqe_pkg::DiffW-1] ? lsqe_pkg::DiffW'(-job_q.dy)
                                             : lsqe_pkg::DiffW'(job_q.dy);

  // Clamp the unit components, widen the half width by one pixel
  assign ucx = (qx_q > lsqe_pkg::QuotW'(lsqe_pkg::UnitMax)) ?
               lsqe_pkg::UnitW'(lsqe_pkg::UnitMax) : qx_q[lsqe_pkg::UnitW-1:0];
  assign ucy = (qy_q > lsqe_pkg::QuotW'(lsqe_pkg::UnitMax)) ?
               lsqe_pkg::UnitW'(lsqe_pkg::UnitMax) : qy_q[lsqe_pkg::UnitW-1:0];
  assign ext = lsqe_pkg::ExtW'(job_q.seg.w) + (lsqe_pkg::ExtW'(1) << FracBits);

  assign rsx = prx_q + lsqe_pkg::ProdW'(lsqe_pkg::RoundHalf);
  assign rsy = pry_q + lsqe_pkg::ProdW'(lsqe_pkg::RoundHalf);

  // Sequence root, divide, scale and round
  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    rad_d   = rad_q;
    res_d   = res_q;
    bit_d   = bit_q;
    remx_d  = remx_q;
    remy_d  = remy_q;
    dv_d    = dv_q;
    qx_d    = qx_q;
    qy_d    = qy_q;
    cnt_d   = cnt_q;
    prx_d   = prx_q;
    pry_d   = pry_q;
    ox_d    = ox_q;
    oy_d    = oy_q;
    unique case (state_q)
      StIdle: begin
        if (job_valid_i) begin
          job_d = job_i;
          if (job_i.zero) begin
            state_d = StDone;
          end else begin
            rad_d   = {job_i.sq, 14'b0};
            res_d   = '0;
            bit_d   = {2'b01, {(lsqe_pkg::RadW-2){1'b0}}};
            state_d = StRoot;
          end
        end
      end
      StRoot: begin
        if (take) rad_d = rad_q - trial;
        res_d = res_step;
        bit_d = bit_q >> 2;
        if (bit_q[0]) begin
          remx_d  = {1'b0, magx, 22'b0} + lsqe_pkg::DivW'(root >> 1);
          remy_d  = {1'b0, magy, 22'b0} + lsqe_pkg::DivW'(root >> 1);
          dv_d    = {root, 16'b0};
          qx_d    = '0;
          qy_d    = '0;
          cnt_d   = '0;
          state_d = StDiv;
        end
      end
      StDiv: begin
        if (remx_q >= dv_q) begin
          remx_d = remx_q - dv_q;
          qx_d   = {qx_q[lsqe_pkg::QuotW-2:0], 1'b1};
        end else begin
          qx_d   = {qx_q[lsqe_pkg::QuotW-2:0], 1'b0};
        end
        if (remy_q >= dv_q) begin
          remy_d = remy_q - dv_q;
          qy_d   = {qy_q[lsqe_pkg::QuotW-2:0], 1'b1};
        end else begin
          qy_d   = {qy_q[lsqe_pkg::QuotW-2:0], 1'b0};
        end
        dv_d  = dv_q >> 1;
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(DivSteps - 1)) state_d = StMul;
      end
      StMul: begin
        prx_d   = lsqe_pkg::ProdW'(ucx) * lsqe_pkg::ProdW'(ext);
        pry_d   = lsqe_pkg::ProdW'(ucy) * lsqe_pkg::ProdW'(ext);
        state_d = StRnd;
      end
      StRnd: begin
        ox_d = job_q.dx[lsqe_pkg::DiffW-1] ?
               -$signed(lsqe_pkg::OffW'(rsx[lsqe_pkg::ProdW-1:15])) :
               $signed(lsqe_pkg::OffW'(rsx[lsqe_pkg::ProdW-1:15]));
        oy_d = job_q.dy[lsqe_pkg::DiffW-1] ?
               -$signed(lsqe_pkg::OffW'(rsy[lsqe_pkg::ProdW-1:15])) :
               $signed(lsqe_pkg::OffW'(rsy[lsqe_pkg::ProdW-1:15]));
        state_d = StDone;
      end
      StDone: begin
        if (quad_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    rad_q  <= rad_d;
    res_q  <= res_d;
    bit_q  <= bit_d;
    remx_q <= remx_d;
    remy_q <= remy_d;
    dv_q   <= dv_d;
    qx_q   <= qx_d;
    qy_q   <= qy_d;
    cnt_q  <= cnt_d;
    prx_q  <= prx_d;
    pry_q  <= pry_d;
    ox_q   <= ox_d;
    oy_q   <= oy_d;
  end

  assign job_ready_o  = (state_q == StIdle);
  assign quad_valid_o = (state_q == StDone);

  // Build the four corners and saturate them
  logic signed [lsqe_pkg::SumW-1:0] sxe, sye, exe, eye, oxe, oye, we;
  always_comb begin
    sxe = lsqe_pkg::ext_coord(job_q.seg.sx);
    sye = lsqe_pkg::ext_coord(job_q.seg.sy);
    exe = lsqe_pkg::ext_coord(job_q.seg.ex);
    eye = lsqe_pkg::ext_coord(job_q.seg.ey);
    oxe = lsqe_pkg::SumW'(ox_q);
    oye = lsqe_pkg::SumW'(oy_q);
    we  = $signed(lsqe_pkg::SumW'(job_q.seg.w));
    quad_o.seg = job_q.seg;
    if (job_q.zero) begin
      quad_o.cx[0] = lsqe_pkg::sat_coord(sxe + we);
      quad_o.cy[0] = lsqe_pkg::sat_coord(sye + we);
      quad_o.cx[1] = lsqe_pkg::sat_coord(sxe + we);
      quad_o.cy[1] = lsqe_pkg::sat_coord(sye - we);
      quad_o.cx[2] = lsqe_pkg::sat_coord(sxe - we);
      quad_o.cy[2] = lsqe_pkg::sat_coord(sye + we);
      quad_o.cx[3] = lsqe_pkg::sat_coord(sxe - we);
      quad_o.cy[3] = lsqe_pkg::sat_coord(sye - we);
    end else begin
      quad_o.cx[0] = lsqe_pkg::sat_coord(sxe - oxe - oye);
      quad_o.cy[0] = lsqe_pkg::sat_coord(sye - oye + oxe);
      quad_o.cx[1] = lsqe_pkg::sat_coord(exe + oxe - oye);
      quad_o.cy[1] = lsqe_pkg::sat_coord(eye + oye + oxe);
      quad_o.cx[2] = lsqe_pkg::sat_coord(sxe - oxe + oye);
      quad_o.cy[2] = lsqe_pkg::sat_coord(sye - oye - oxe);
      quad_o.cx[3] = lsqe_pkg::sat_coord(exe + oxe + oye);
      quad_o.cy[3] = lsqe_pkg::sat_coord(eye + oye - oxe);
    end
  end

endmodule

@@ rtl/core/lsqe_emit.sv @@
module lsqe_emit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               quad_valid_i,
  output logic                               quad_ready_o,
  input  lsqe_pkg::quad_t                    quad_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [lsqe_pkg::CoordW-1:0] corner_x_o,
  output logic signed [lsqe_pkg::CoordW-1:0] corner_y_o,
  output lsqe_pkg::seg_t                     seg_o,
  output logic                               last_vertex_o
);

  logic                         valid_q;
  logic [lsqe_pkg::VtxCntW-1:0] cnt_q;
  lsqe_pkg::quad_t              quad_q;
  logic [1:0]                   sel;
  logic                         xfer, last;

  assign last         = (cnt_q == lsqe_pkg::VtxCntW'(lsqe_pkg::NumVertices - 1));
  assign xfer         = valid_q && !out_stall_i;
  assign quad_ready_o = !valid_q || (xfer && last);

  // Step through the vertices of the current quad
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else if (quad_ready_o && quad_valid_i) begin
      valid_q <= 1'b1;
      cnt_q   <= '0;
    end else if (xfer) begin
      if (last) valid_q <= 1'b0;
      cnt_q <= cnt_q + lsqe_pkg::VtxCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (quad_ready_o && quad_valid_i) quad_q <= quad_i;
  end

  // Map the vertex slot to its corner
  always_comb begin
    unique case (cnt_q)
      3'd0:    sel = 2'd0;
      3'd1:    sel = 2'd1;
      3'd2:    sel = 2'd2;
      3'd3:    sel = 2'd1;
      3'd4:    sel = 2'd2;
      default: sel = 2'd3;
    endcase
  end

  assign out_valid_o   = valid_q;
  assign corner_x_o    = quad_q.cx[sel];
  assign corner_y_o    = quad_q.cy[sel];
  assign seg_o         = quad_q.seg;
  assign last_vertex_o = last;

endmodule

@@ rtl/core/line_segment_quad_expander_unit.sv @@
// Line segment to quad expander.
// Input channel: in_valid_i / in_stall_o carries one segment (two endpoints in
// signed Q16.8, a Q8.8 half width, a packed RGBA colour) per transfer.
// Output channel: out_valid_o / out_stall_i carries six vertices per segment,
// corners c1,c2,c3,c2,c3,c4, each with the segment fields unchanged;
// last_vertex_o marks the sixth.
// A nonzero-length segment goes through the shared normaliser (bit-serial
// square root, two parallel restoring dividers, then scale and round); a
// zero-length segment skips all of these steps. The normaliser takes a new
// segment only after its quad has been taken by the vertex stage. A
// two-entry queue lets the front keep taking segments while the normaliser
// works, and the vertex register lets the next quad be normalised while the
// current one drains.
// Reset clears all valid flags and the queue; no vertex is presented until a
// segment is transferred. A stall at the output holds the current vertex;
// back-pressure then reaches in_stall_o once the queue and front stages fill.
module line_segment_quad_expander_unit #(
  parameter int FRAC_BITS = lsqe_pkg::FracBitsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [lsqe_pkg::CoordW-1:0] start_x_i,
  input  logic signed [lsqe_pkg::CoordW-1:0] start_y_i,
  input  logic signed [lsqe_pkg::CoordW-1:0] end_x_i,
  input  logic signed [lsqe_pkg::CoordW-1:0] end_y_i,
  input  logic [lsqe_pkg::WidthW-1:0]        half_width_i,
  input  logic [lsqe_pkg::ColorW-1:0]        rgba_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [lsqe_pkg::CoordW-1:0] corner_x_o,
  output logic signed [lsqe_pkg::CoordW-1:0] corner_y_o,
  output logic signed [lsqe_pkg::CoordW-1:0] seg_start_x_o,
  output logic signed [lsqe_pkg::CoordW-1:0] seg_start_y_o,
  output logic signed [lsqe_pkg::CoordW-1:0] seg_end_x_o,
  output logic signed [lsqe_pkg::CoordW-1:0] seg_end_y_o,
  output logic [lsqe_pkg::ColorW-1:0]        vertex_color_o,
  output logic [lsqe_pkg::WidthW-1:0]        vertex_width_o,
  output logic                               last_vertex_o
);

  lsqe_pkg::seg_t  seg_in, seg_out;
  lsqe_pkg::job_t  fj, qj;
  lsqe_pkg::quad_t quad;
  logic            fj_valid, fj_ready, qj_valid, qj_ready, quad_valid, quad_ready;

  // Gather the segment fields
  always_comb begin
    seg_in.sx   = start_x_i;
    seg_in.sy   = start_y_i;
    seg_in.ex   = end_x_i;
    seg_in.ey   = end_y_i;
    seg_in.w    = half_width_i;
    seg_in.rgba = rgba_i;
  end

  lsqe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .seg_i       (seg_in),
    .job_valid_o (fj_valid),
    .job_ready_i (fj_ready),
    .job_o       (fj)
  );

  lsqe_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fj_valid),
    .push_ready_o (fj_ready),
    .push_data_i  (fj),
    .pop_valid_o  (qj_valid),
    .pop_ready_i  (qj_ready),
    .pop_data_o   (qj)
  );

  lsqe_norm #(
    .FracBits (FRAC_BITS)
  ) u_norm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (qj_valid),
    .job_ready_o  (qj_ready),
    .job_i        (qj),
    .quad_valid_o (quad_valid),
    .quad_ready_i (quad_ready),
    .quad_o       (quad)
  );

  lsqe_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .quad_valid_i  (quad_valid),
    .quad_ready_o  (quad_ready),
    .quad_i        (quad),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .corner_x_o    (corner_x_o),
    .corner_y_o    (corner_y_o),
    .seg_o         (seg_out),
    .last_vertex_o (last_vertex_o)
  );

  assign seg_start_x_o  = seg_out.sx;
  assign seg_start_y_o  = seg_out.sy;
  assign seg_end_x_o    = seg_out.ex;
  assign seg_end_y_o    = seg_out.ey;
  assign vertex_color_o = seg_out.rgba;
  assign vertex_width_o = seg_out.w;

endmodule

@@ rtl/core/lsqe_checker.sv @@
module lsqe_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [lsqe_pkg::CoordW-1:0] corner_x_o,
  input logic [lsqe_pkg::CoordW-1:0] corner_y_o,
  input logic [lsqe_pkg::CoordW-1:0] seg_start_x_o,
  input logic [lsqe_pkg::CoordW-1:0] seg_end_y_o,
  input logic [lsqe_pkg::ColorW-1:0] vertex_color_o,
  input logic                        last_vertex_o
);

  logic [lsqe_pkg::VtxCntW-1:0] vcnt_q;
  logic                         xfer;

  assign xfer = out_valid_o && !out_stall_i;

  // Count vertex transfers within a quad
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcnt_q <= '0;
    end else if (xfer) begin
      vcnt_q <= (vcnt_q == lsqe_pkg::VtxCntW'(lsqe_pkg::NumVertices - 1)) ?
                '0 : vcnt_q + lsqe_pkg::VtxCntW'(1);
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(corner_x_o) && $stable(corner_y_o))
    else $error("vertex changed under stall");

  a_last_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_vertex_o ==
                     (vcnt_q == lsqe_pkg::VtxCntW'(lsqe_pkg::NumVertices - 1))))
    else $error("last vertex flag out of step with vertex count");

  a_quad_whole: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && !last_vertex_o |=> out_valid_o && $stable(seg_start_x_o)
                               && $stable(seg_end_y_o) && $stable(vertex_color_o))
    else $error("quad broken before its sixth vertex");

endmodule

bind line_segment_quad_expander_unit lsqe_checker u_lsqe_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .corner_x_o     (corner_x_o),
  .corner_y_o     (corner_y_o),
  .seg_start_x_o  (seg_start_x_o),
  .seg_end_y_o    (seg_end_y_o),
  .vertex_color_o (vertex_color_o),
  .last_vertex_o  (last_vertex_o)
);

@@ bench/tb_top.sv @@
module tb_top;

  localparam int FracBits = 8;
  localparam int NumRandom = 150;
  localparam int HoldOffCycles = 400;

  typedef struct packed {
    logic signed [lsqe_pkg::CoordW-1:0] cx;
    logic signed [lsqe_pkg::CoordW-1:0] cy;
    logic signed [lsqe_pkg::CoordW-1:0] sx;
    logic signed [lsqe_pkg::CoordW-1:0] sy;
    logic signed [lsqe_pkg::CoordW-1:0] ex;
    logic signed [lsqe_pkg::CoordW-1:0] ey;
    logic [lsqe_pkg::ColorW-1:0]        color;
    logic [lsqe_pkg::WidthW-1:0]        w;
    logic                               last;
  } vertex_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [lsqe_pkg::CoordW-1:0] sx_d = '0, sy_d = '0, ex_d = '0, ey_d = '0;
  logic [lsqe_pkg::WidthW-1:0] w_d = '0;
  logic [lsqe_pkg::ColorW-1:0] rgba_d = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [lsqe_pkg::CoordW-1:0] got_cx, got_cy, got_sx, got_sy, got_ex, got_ey;
  logic [lsqe_pkg::ColorW-1:0] got_color;
  logic [lsqe_pkg::WidthW-1:0] got_w;
  logic got_last;
  vertex_t got;

  lsqe_pkg::seg_t pending_segs[$];
  vertex_t vertex_q[$];
  int      n_errors = 0;
  bit      stim_done = 1'b0;
  bit      quiet = 1'b0;
  bit      hold_off = 1'b0;
  bit      sender_pause = 1'b0;
  int      in_gap = 0;
  int      out_gap = 0;

  line_segment_quad_expander_unit #(.FRAC_BITS(FracBits)) uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .start_x_i(sx_d), .start_y_i(sy_d), .end_x_i(ex_d), .end_y_i(ey_d),
    .half_width_i(w_d), .rgba_i(rgba_d),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .corner_x_o(got_cx), .corner_y_o(got_cy),
    .seg_start_x_o(got_sx), .seg_start_y_o(got_sy),
    .seg_end_x_o(got_ex), .seg_end_y_o(got_ey),
    .vertex_color_o(got_color), .vertex_width_o(got_w),
    .last_vertex_o(got_last)
  );

  assign got = {got_cx, got_cy, got_sx, got_sy, got_ex, got_ey, got_color, got_w, got_last};

  initial forever #4 clk = ~clk;

  // Integer square root, bit by bit
  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Divide, rounding half away from zero
  function automatic longint round_div(input longint num, input longint den);
    longint mag;
    mag = (num < 0) ? -num : num;
    mag = (mag + den / 2) / den;
    return (num < 0) ? -mag : mag;
  endfunction

  function automatic longint clip(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim - 1) return -lim - 1;
    return v;
  endfunction

  // Queue the six vertices of one segment
  task automatic expand_segment(input lsqe_pkg::seg_t s);
    longint sx, sy, ex, ey, w, dx, dy, len7, ux, uy, ext, ox, oy;
    longint cx[4], cy[4];
    int order[6];
    vertex_t v;
    order = '{0, 1, 2, 1, 2, 3};
    sx = s.sx; sy = s.sy; ex = s.ex; ey = s.ey; w = s.w;
    dx = ex - sx; dy = ey - sy;
    if (dx == 0 && dy == 0) begin
      cx[0] = sx + w; cy[0] = sy + w;
      cx[1] = sx + w; cy[1] = sy - w;
      cx[2] = sx - w; cy[2] = sy + w;
      cx[3] = sx - w; cy[3] = sy - w;
    end else begin
      len7 = int_sqrt((dx * dx + dy * dy) << 14);
      ux = clip(round_div(dx * 4194304, len7), 32767);
      uy = clip(round_div(dy * 4194304, len7), 32767);
      if (ux < -32767) ux = -32767;
      if (uy < -32767) uy = -32767;
      ext = w + (64'd1 << FracBits);
      ox = round_div(ux * ext, 32768);
      oy = round_div(uy * ext, 32768);
      cx[0] = sx - ox - oy; cy[0] = sy - oy + ox;
      cx[1] = ex + ox - oy; cy[1] = ey + oy + ox;
      cx[2] = sx - ox + oy; cy[2] = sy - oy - ox;
      cx[3] = ex + ox + oy; cy[3] = ey + oy - ox;
    end
    for (int k = 0; k < 6; k++) begin
      v.cx = lsqe_pkg::CoordW'(clip(cx[order[k]], lsqe_pkg::CoordMax));
      v.cy = lsqe_pkg::CoordW'(clip(cy[order[k]], lsqe_pkg::CoordMax));
      v.sx = s.sx; v.sy = s.sy; v.ex = s.ex; v.ey = s.ey;
      v.color = s.rgba; v.w = s.w; v.last = (k == 5);
      vertex_q.push_back(v);
    end
  endtask

  task automatic report(input string what, input logic [63:0] g, input logic [63:0] e);
    $display("mismatch %s: got %0h expected %0h", what, g, e);
    n_errors++;
  endtask

  function automatic lsqe_pkg::seg_t make_seg(input int sx, input int sy, input int ex,
                                              input int ey, input int w, input int c);
    lsqe_pkg::seg_t s;
    s.sx = lsqe_pkg::CoordW'(sx);
    s.sy = lsqe_pkg::CoordW'(sy);
    s.ex = lsqe_pkg::CoordW'(ex);
    s.ey = lsqe_pkg::CoordW'(ey);
    s.w = lsqe_pkg::WidthW'(w);
    s.rgba = c;
    return s;
  endfunction

  function automatic logic [lsqe_pkg::CoordW-1:0] rand_coord();
    int v;
    case ($urandom_range(0, 3))
      0: v = int'($urandom);
      1: v = int'($urandom_range(0, 4095)) - 2048;
      2: v = $urandom_range(0, 1) ? lsqe_pkg::CoordMax : -lsqe_pkg::CoordMax - 1;
      default: v = int'($urandom_range(0, 1 << 16)) - (1 << 15);
    endcase
    return lsqe_pkg::CoordW'(v);
  endfunction

  // Fill the segment queue: directed first, then random
  initial begin
    lsqe_pkg::seg_t s;
    pending_segs.push_back(make_seg(0, 0, 0, 0, 0, 0));
    pending_segs.push_back(make_seg(100, -200, 100, -200, 65535, -1));
    pending_segs.push_back(make_seg(lsqe_pkg::CoordMax, lsqe_pkg::CoordMax,
                                    lsqe_pkg::CoordMax, lsqe_pkg::CoordMax, 65535, 32'h12345678));
    pending_segs.push_back(make_seg(-lsqe_pkg::CoordMax-1, -lsqe_pkg::CoordMax-1,
                                    -lsqe_pkg::CoordMax-1, -lsqe_pkg::CoordMax-1, 65535, 7));
    pending_segs.push_back(make_seg(0, 0, 256, 0, 256, 32'hff00ff00));
    pending_segs.push_back(make_seg(0, 0, 0, 256, 128, 1));
    pending_segs.push_back(make_seg(0, 0, -256, 0, 0, 2));
    pending_segs.push_back(make_seg(0, 0, 0, -1, 65535, 3));
    pending_segs.push_back(make_seg(0, 0, 1, 1, 100, 4));
    pending_segs.push_back(make_seg(-lsqe_pkg::CoordMax-1, -lsqe_pkg::CoordMax-1,
                                    lsqe_pkg::CoordMax, lsqe_pkg::CoordMax, 65535, -1));
    pending_segs.push_back(make_seg(lsqe_pkg::CoordMax, -lsqe_pkg::CoordMax-1,
                                    -lsqe_pkg::CoordMax-1, lsqe_pkg::CoordMax, 65535, 5));
    pending_segs.push_back(make_seg(lsqe_pkg::CoordMax-10, 0, lsqe_pkg::CoordMax, 0, 65535, 6));
    pending_segs.push_back(make_seg(-lsqe_pkg::CoordMax-1, 5, -lsqe_pkg::CoordMax-1, -5,
                                    65535, 8));
    pending_segs.push_back(make_seg(1000, 1000, 1003, -4000, 77, 9));
    for (int i = 0; i < NumRandom; i++) begin
      s.sx = rand_coord();
      s.sy = rand_coord();
      if ($urandom_range(0, 7) == 0) begin
        s.ex = s.sx; s.ey = s.sy;
      end else begin
        s.ex = rand_coord(); s.ey = rand_coord();
      end
      s.w = lsqe_pkg::WidthW'($urandom);
      s.rgba = $urandom;
      pending_segs.push_back(s);
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Drive segments, with gaps and one pause until the output drains
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) expand_segment('{sx_d, sy_d, ex_d, ey_d, w_d, rgba_d});
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (sender_pause && (vertex_q.size() > 0 || (in_valid && !in_stall))) begin
          in_valid <= 1'b0;
        end else if (pending_segs.size() == 0) begin
          in_valid <= 1'b0;
          stim_done <= 1'b1;
        end else begin
          if (pending_segs.size() == 100) sender_pause <= 1'b1;
          else sender_pause <= 1'b0;
          if (!quiet && $urandom_range(0, 3) == 0) begin
            in_gap <= int'($urandom_range(0, 2));
            in_valid <= 1'b0;
          end else begin
            {sx_d, sy_d, ex_d, ey_d, w_d, rgba_d} <= pending_segs.pop_front();
            in_valid <= 1'b1;
          end
        end
      end
      quiet <= (pending_segs.size() < 25);
    end
  end

  // Long receiver hold-off while the sender keeps offering
  initial begin
    wait (rst_n);
    wait (pending_segs.size() < 140);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HoldOffCycles) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Check each vertex transfer and drive the stall
  always @(posedge clk) begin
    vertex_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (vertex_q.size() == 0) begin
          report("unexpected vertex", 64'(got_cx), 64'd0);
        end else begin
          e = vertex_q.pop_front();
          if (got.cx !== e.cx) report("corner_x", 64'(got.cx), 64'(e.cx));
          if (got.cy !== e.cy) report("corner_y", 64'(got.cy), 64'(e.cy));
          if (got.sx !== e.sx) report("seg_start_x", 64'(got.sx), 64'(e.sx));
          if (got.sy !== e.sy) report("seg_start_y", 64'(got.sy), 64'(e.sy));
          if (got.ex !== e.ex) report("seg_end_x", 64'(got.ex), 64'(e.ex));
          if (got.ey !== e.ey) report("seg_end_y", 64'(got.ey), 64'(e.ey));
          if (got.color !== e.color) report("vertex_color", 64'(got.color), 64'(e.color));
          if (got.w !== e.w) report("vertex_width", 64'(got.w), 64'(e.w));
          if (got.last !== e.last) report("last_vertex", 64'(got.last), 64'(e.last));
        end
      end
      if (hold_off) begin
        out_stall <= 1'b1;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_gap <= int'($urandom_range(0, 2));
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Wait for the drain, then settle
  initial begin
    wait (stim_done);
    wait (vertex_q.size() == 0);
    repeat (100) @(posedge clk);
    if (n_errors == 0 && vertex_q.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end
endmodule
